// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/ltd_pkg.sv -----
// Package: types and constants of the light-curve detection trigger
`timescale 1ns / 1ps
package ltd_pkg;
    localparam int MAG_W     = 24;
    localparam int EPOCH_W   = 32;
    localparam int CHI_W     = 32;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int CHI_SHIFT = 8;
    localparam int NUM_W     = SQ_W + CHI_SHIFT;
    localparam int OUT_RUN_W = 16;
    localparam int CFG_RUN_W = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAG_W-1:0] ONE_Q16 = MAG_W'(65536);
    localparam logic [CHI_W-1:0] CHI_MAX = '1;

    typedef enum logic [2:0] {
        REG_POINT_THR     = 3'd0,
        REG_TOTAL_THR     = 3'd1,
        REG_MIN_RUN       = 3'd2,
        REG_GAP_LIMIT     = 3'd3,
        REG_CURVE_INVALID = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_SQUARE,
        FE_START,
        FE_DIVIDE,
        FE_PUSH
    } t_fe_state;

    typedef struct packed {
        logic [CHI_W-1:0]   chi_flat;
        logic [CHI_W-1:0]   chi_model;
        logic [EPOCH_W-1:0] epoch;
        logic               unsat;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [31:0]          point_thr;
        logic [31:0]          total_thr;
        logic [CFG_RUN_W-1:0] min_run;
        logic [EPOCH_W-1:0]   gap_limit;
        logic                 curve_invalid;
    } t_cfg;
endpackage

// ----- hw/rtl/ltd_if.sv -----
// Interfaces: point input channel and group result channel
`timescale 1ns / 1ps
interface ltd_pt_if import ltd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   observed_mag;
    logic [MAG_W-1:0]   model_mag;
    logic [MAG_W-1:0]   mag_error;
    logic [EPOCH_W-1:0] epoch_time;
    logic               unsaturated;
    logic               group_last;

    modport source (output valid, observed_mag, model_mag, mag_error, epoch_time,
                    unsaturated, group_last, input ready);
    modport sink (input valid, observed_mag, model_mag, mag_error, epoch_time,
                  unsaturated, group_last, output ready);
endinterface

interface ltd_res_if import ltd_pkg::*; #(parameter int SUM_BITS = 48) ();
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] delta_chi2;
    logic signed [SUM_BITS-1:0] strong_chi2;
    logic [OUT_RUN_W-1:0]       longest_run;
    logic                       group_detected;
    logic                       flat_curve;

    modport source (output valid, delta_chi2, strong_chi2, longest_run, group_detected,
                    flat_curve, input ready);
    modport sink (input valid, delta_chi2, strong_chi2, longest_run, group_detected,
                  flat_curve, output ready);
endinterface

// ----- hw/rtl/ltd_div.sv -----
// Iterative restoring divider: saturating 32-bit quotient, one bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ltd_div import ltd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [SQ_W-1:0]  i_den,
    output logic             o_busy,
    output logic [CHI_W-1:0] o_quot
);
    localparam int DSH_W = SQ_W + CHI_W - 1;
    localparam int SAT_W = SQ_W + CHI_W;
    localparam int CNT_W = $clog2(CHI_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [CHI_W-1:0] r_quot;
    logic             w_sat;
    logic             w_ge;

    assign w_sat = (i_den == '0) || (SAT_W'(i_num) >= {i_den, {CHI_W{1'b0}}});
    assign w_ge  = DSH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_sat;
            r_cnt  <= w_sat ? '0 : CNT_W'(CHI_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(CHI_W-1){1'b0}}};
            r_quot <= w_sat ? CHI_MAX : '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= NUM_W'(DSH_W'(r_rem) - r_dsh);
            end
            r_quot <= {r_quot[CHI_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy, "start while busy")
    `ASSERT_PROP(a_busy_count, i_clk, i_rst_n, r_busy |-> r_cnt != '0, "busy with zero count")
    `ASSERT_PROP(a_last_step, i_clk, i_rst_n, (r_busy && r_cnt == CNT_W'(1) && !i_start) |=> !r_busy,
        "divider did not finish")
endmodule

// ----- hw/rtl/ltd_front.sv -----
// Front end: accepts points, squares the differences, runs both chi2 divisions
`timescale 1ns / 1ps
module ltd_front import ltd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ltd_pt_if.sink    i_pt,
    input  logic      i_full,
    output logic      o_push,
    output t_job      o_job
);
    t_fe_state r_state, n_state;

    logic [MAG_W-1:0]   r_obs, r_mdl, r_err;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_unsat, r_last;
    logic [SQ_W-1:0]    r_sq_flat, r_sq_model, r_sq_err;
    logic signed [MAG_W:0] w_d_flat, w_d_model;
    logic [MAG_W-1:0]   w_a_flat, w_a_model;
    logic               w_start;
    logic               w_busy_flat, w_busy_model;
    logic [CHI_W-1:0]   w_q_flat, w_q_model;

    assign w_d_flat  = $signed({1'b0, r_obs}) - $signed({1'b0, ONE_Q16});
    assign w_d_model = $signed({1'b0, r_obs}) - $signed({1'b0, r_mdl});
    assign w_a_flat  = w_d_flat[MAG_W]  ? MAG_W'(-w_d_flat)  : w_d_flat[MAG_W-1:0];
    assign w_a_model = w_d_model[MAG_W] ? MAG_W'(-w_d_model) : w_d_model[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE:   if (i_pt.valid) n_state = FE_SQUARE;
            FE_SQUARE: n_state = FE_START;
            FE_START:  n_state = FE_DIVIDE;
            FE_DIVIDE: if (!w_busy_flat && !w_busy_model) n_state = FE_PUSH;
            FE_PUSH:   if (!i_full) n_state = FE_IDLE;
            default:   n_state = FE_IDLE;
        endcase
    end

    always_comb begin
        i_pt.ready = r_state == FE_IDLE;
        w_start    = r_state == FE_START;
        o_push     = (r_state == FE_PUSH) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready) begin
            r_obs   <= i_pt.observed_mag;
            r_mdl   <= i_pt.model_mag;
            r_err   <= i_pt.mag_error;
            r_epoch <= i_pt.epoch_time;
            r_unsat <= i_pt.unsaturated;
            r_last  <= i_pt.group_last;
        end
        if (r_state == FE_SQUARE) begin
            r_sq_flat  <= w_a_flat * w_a_flat;
            r_sq_model <= w_a_model * w_a_model;
            r_sq_err   <= r_err * r_err;
        end
    end

    ltd_div u_div_flat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({r_sq_flat, {CHI_SHIFT{1'b0}}}),
        .i_den   (r_sq_err),
        .o_busy  (w_busy_flat),
        .o_quot  (w_q_flat)
    );

    ltd_div u_div_model (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({r_sq_model, {CHI_SHIFT{1'b0}}}),
        .i_den   (r_sq_err),
        .o_busy  (w_busy_model),
        .o_quot  (w_q_model)
    );

    assign o_job = '{chi_flat: w_q_flat, chi_model: w_q_model, epoch: r_epoch,
                     unsat: r_unsat, last: r_last};
endmodule

// ----- hw/rtl/ltd_fifo.sv -----
// Short job queue between front and back end
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ltd_fifo import ltd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_job  o_job
);
    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];

    `ASSERT_NEVER(a_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `ASSERT_PROP(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1,
        "queue count did not grow")
endmodule

// ----- hw/rtl/ltd_back.sv -----
// Back end: accumulates sums and runs per group and registers the result
`timescale 1ns / 1ps
module ltd_back import ltd_pkg::*; #(
    parameter int SUM_BITS = 48,
    parameter int RUN_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_job      i_job,
    input  t_cfg      i_cfg,
    output logic      o_pop,
    ltd_res_if.source o_res
);
    localparam int ACC_W = ((SUM_BITS > CHI_W + 1) ? SUM_BITS : CHI_W + 1) + 1;
    localparam int RUN_EXT = (RUN_BITS > OUT_RUN_W) ? RUN_BITS : OUT_RUN_W;
    localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic [RUN_BITS-1:0]        r_run, r_best, n_run, n_best;
    logic [EPOCH_W-1:0]         r_prev_ep, n_prev_ep;
    logic                       r_prev_vld, n_prev_vld;
    logic signed [SUM_BITS-1:0] r_delta, r_strong, n_delta, n_strong;
    logic signed [SUM_BITS-1:0] s_delta, s_strong;
    logic [RUN_BITS-1:0]        s_best;
    logic signed [CHI_W:0]      w_diff;
    logic                       w_consec, w_emit;
    logic [RUN_EXT-1:0]         w_best_ext;
    logic                       r_out_vld;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] s,
        input logic signed [CHI_W:0]      v
    );
        logic signed [ACC_W-1:0] t;
        t = ACC_W'(s) + ACC_W'(v);
        if (t > ACC_W'(SUM_HI)) return SUM_HI;
        if (t < ACC_W'(SUM_LO)) return SUM_LO;
        return SUM_BITS'(t);
    endfunction

    assign o_pop    = i_valid && (!r_out_vld || o_res.ready);
    assign w_diff   = $signed({1'b0, i_job.chi_flat}) - $signed({1'b0, i_job.chi_model});
    assign w_consec = r_prev_vld && (i_job.epoch > r_prev_ep)
                      && ((i_job.epoch - r_prev_ep) < i_cfg.gap_limit);

    always_comb begin
        s_delta    = r_delta;
        s_strong   = r_strong;
        s_best     = r_best;
        n_run      = r_run;
        n_prev_ep  = r_prev_ep;
        n_prev_vld = r_prev_vld;
        w_emit     = 1'b0;
        if (!i_cfg.curve_invalid) begin
            if (i_job.unsat) begin
                s_delta = sat_add(r_delta, w_diff);
                if (i_job.chi_flat > i_cfg.point_thr) begin
                    s_strong = sat_add(r_strong, w_diff);
                    if (w_consec) begin
                        n_run = (r_run != '1) ? r_run + 1'b1 : r_run;
                        if (n_run > r_best) s_best = n_run;
                    end else begin
                        n_run = RUN_BITS'(1);
                    end
                end else begin
                    n_run = '0;
                end
            end
            n_prev_ep  = i_job.epoch;
            n_prev_vld = 1'b1;
            w_emit     = i_job.last;
        end
        n_delta  = s_delta;
        n_strong = s_strong;
        n_best   = s_best;
        if (i_job.last) begin
            n_run      = '0;
            n_best     = '0;
            n_prev_ep  = '0;
            n_prev_vld = 1'b0;
            n_delta    = '0;
            n_strong   = '0;
        end
    end

    assign w_best_ext = RUN_EXT'(s_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= '0;
            r_best     <= '0;
            r_prev_ep  <= '0;
            r_prev_vld <= 1'b0;
            r_delta    <= '0;
            r_strong   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_run      <= n_run;
                r_best     <= n_best;
                r_prev_ep  <= n_prev_ep;
                r_prev_vld <= n_prev_vld;
                r_delta    <= n_delta;
                r_strong   <= n_strong;
            end
            if (o_pop && w_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            o_res.delta_chi2     <= s_delta;
            o_res.strong_chi2    <= s_strong;
            o_res.longest_run    <= w_best_ext[OUT_RUN_W-1:0];
            o_res.group_detected <= (ACC_W'(s_delta) > $signed(ACC_W'(i_cfg.total_thr)))
                                    && (w_best_ext >= RUN_EXT'(i_cfg.min_run));
            o_res.flat_curve     <= s_best == '0;
        end
    end

    assign o_res.valid = r_out_vld;
endmodule

// ----- hw/rtl/lightcurve_detection_trigger.sv -----
// Top level: light-curve detection trigger with APB configuration
`timescale 1ns / 1ps
// Takes one light-curve point per transaction and returns one result per group on
// the point flagged group_last (none while curve_invalid is set). The time a point
// takes is set by the two 32-step chi2 dividers in the front end that run side by
// side; a point with zero error skips the division. The back end accumulates each
// job from a two-entry queue, so a result can wait on the output while the next point
// is already being divided. Registers sit at byte addresses 0, 4, 8, 12, 16.
module lightcurve_detection_trigger import ltd_pkg::*; #(
    parameter int SUM_BITS = 48,
    parameter int RUN_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ltd_pt_if.sink             i_pt,
    ltd_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    t_cfg     r_cfg;
    t_reg_idx w_idx;
    t_job     w_fe_job, w_be_job;
    logic     w_push, w_full, w_pop, w_q_valid;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_thr     <= 32'd2304;
            r_cfg.total_thr     <= 32'd20480;
            r_cfg.min_run       <= CFG_RUN_W'(3);
            r_cfg.gap_limit     <= 32'd65536;
            r_cfg.curve_invalid <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_POINT_THR:     r_cfg.point_thr     <= pwdata;
                REG_TOTAL_THR:     r_cfg.total_thr     <= pwdata;
                REG_MIN_RUN:       r_cfg.min_run       <= pwdata[CFG_RUN_W-1:0];
                REG_GAP_LIMIT:     r_cfg.gap_limit     <= pwdata;
                REG_CURVE_INVALID: r_cfg.curve_invalid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_POINT_THR:     prdata = r_cfg.point_thr;
            REG_TOTAL_THR:     prdata = r_cfg.total_thr;
            REG_MIN_RUN:       prdata = PDATA_W'(r_cfg.min_run);
            REG_GAP_LIMIT:     prdata = r_cfg.gap_limit;
            REG_CURVE_INVALID: prdata = PDATA_W'(r_cfg.curve_invalid);
            default:           prdata = '0;
        endcase
    end

    ltd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_fe_job)
    );

    ltd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fe_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_job   (w_be_job)
    );

    ltd_back #(
        .SUM_BITS (SUM_BITS),
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_job   (w_be_job),
        .i_cfg   (r_cfg),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );
endmodule
